// ----- rtl/core/first_fit_contiguous_allocator_assert.svh -----
// Assertion helpers for the allocator.
`ifndef FIRST_FIT_CONTIGUOUS_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_CONTIGUOUS_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, off while reset is high.
`define FFCA_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, off while reset is high.
`define FFCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

// ----- rtl/core/ffca_pkg.sv -----
package ffca_pkg;

  localparam int SLOTS = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  // wide enough for count + overhead and for SLOTS itself
  localparam int CNT_W = (SLOT_W + 1 > 8) ? SLOT_W + 1 : 8;

  localparam int COUNT_W = 7;
  localparam int RANGE_W = 6;
  localparam int OVH_W = 5;
  localparam int OUT_SLOT_W = 6;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 16;
  localparam logic [OVH_W-1:0] OVH_RESET = OVH_W'(3 + 5);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_EMIT
  } state_t;

  typedef enum logic {
    MODE_ALLOC = 1'b0,
    MODE_FREE  = 1'b1
  } mode_t;

  // Low bits of a slot number as reported on the result channel.
  function automatic logic [OUT_SLOT_W-1:0] slot_out(input logic [SLOT_W-1:0] s);
    logic [CNT_W-1:0] w;
    w = CNT_W'(s);
    return w[OUT_SLOT_W-1:0];
  endfunction

endpackage

// ----- rtl/core/ffca_ram.sv -----
module ffca_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/first_fit_contiguous_allocator.sv -----
// First-fit contiguous slot allocator.
// Input stream (s_axis_*): tuser is the mode (0 allocate, 1 free); tdata
// carries the line count and the free range. One item is worked at a time:
// s_axis_tready is high only while the block is idle.
// Allocate: need = code_line_count + overhead_words. The free map (one bit
// per slot in a synchronous RAM) is scanned one slot per cycle from slot 0,
// then the found run is marked used one slot per cycle. A zero or oversized
// request answers ok=0 without a scan. Free: writes one slot per cycle.
// Configuration: cfg_wr_en writes overhead_words; the user must write it
// only while idle, as the block itself does not enforce this.
// Result stream (m_axis_*): one transfer per item; tuser is ok, tdata holds
// start_slot and end_slot. The result sits in an output register, so a
// stalled receiver only delays the return to idle; nothing is dropped.
// Reset: all slots free (per-slot valid flops, no clearing pass), overhead
// back to 8, both channels empty.
module first_fit_contiguous_allocator (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [ffca_pkg::OVH_W-1:0]           cfg_wr_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // [6:0] code_line_count, [12:7] free_low, [18:13] free_high, rest zero
  input  logic [ffca_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // [0] mode
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // [5:0] start_slot, [11:6] end_slot, rest zero
  output logic [ffca_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // [0] ok
  output logic                                 m_axis_tuser
);

  localparam int SW = ffca_pkg::SLOT_W;
  localparam int CW = ffca_pkg::CNT_W;

  ffca_pkg::state_t state, state_next;

  logic [ffca_pkg::OVH_W-1:0]      overhead;
  logic [CW-1:0]                   need;
  logic [CW-1:0]                   run;
  logic [CW-1:0]                   cur;
  logic [SW-1:0]                   first_slot;
  logic [SW-1:0]                   last_slot;
  logic [ffca_pkg::RANGE_W-1:0]    free_hi;
  logic                            pend;
  logic [SW-1:0]                   pend_idx;
  logic                            vld_q;
  logic [ffca_pkg::SLOTS-1:0]      slot_vld;
  logic                            res_ok;
  logic [ffca_pkg::OUT_SLOT_W-1:0] res_start;
  logic [ffca_pkg::OUT_SLOT_W-1:0] res_end;

  logic                            ram_we;
  logic [SW-1:0]                   ram_waddr;
  logic                            ram_wdata;
  logic [SW-1:0]                   ram_raddr;
  logic                            ram_q;

  logic                            in_xfer;
  logic [CW-1:0]                   need_in;
  logic                            need_bad;
  logic                            scan_issue;
  logic                            scan_free;
  logic                            scan_hit;
  logic                            scan_miss_end;
  logic [SW-1:0]                   hit_first;
  logic [SW-1:0]                   hit_last;
  logic                            free_go;
  logic                            out_free;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign need_in  = CW'(s_axis_tdata[6:0]) + CW'(overhead);
  assign need_bad = (need_in == '0) || (need_in > CW'(ffca_pkg::SLOTS));
  assign out_free = !m_axis_tvalid || m_axis_tready;

  // never-written slots read as free
  assign scan_free     = vld_q ? ram_q : 1'b1;
  assign scan_hit      = pend && scan_free && ((run + CW'(1)) == need);
  assign scan_miss_end = pend && !scan_hit && (pend_idx == SW'(ffca_pkg::SLOTS - 1));
  assign hit_first     = (run == '0) ? pend_idx : first_slot;
  assign hit_last      = SW'(CW'(hit_first) + need - CW'(1));
  assign free_go       = (cur <= CW'(free_hi)) && (cur < CW'(ffca_pkg::SLOTS));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ffca_pkg::ST_IDLE: begin
        if (in_xfer) begin
          if (s_axis_tuser == ffca_pkg::MODE_FREE) begin
            state_next = ffca_pkg::ST_FREE;
          end else if (need_bad) begin
            state_next = ffca_pkg::ST_EMIT;
          end else begin
            state_next = ffca_pkg::ST_SCAN;
          end
        end
      end
      ffca_pkg::ST_SCAN: begin
        if (scan_hit) begin
          state_next = ffca_pkg::ST_MARK;
        end else if (scan_miss_end) begin
          state_next = ffca_pkg::ST_EMIT;
        end
      end
      ffca_pkg::ST_MARK: begin
        if (cur[SW-1:0] == last_slot) begin
          state_next = ffca_pkg::ST_EMIT;
        end
      end
      ffca_pkg::ST_FREE: begin
        if (!free_go) begin
          state_next = ffca_pkg::ST_EMIT;
        end
      end
      ffca_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = ffca_pkg::ST_IDLE;
        end
      end
      default: state_next = ffca_pkg::ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    s_axis_tready = (state == ffca_pkg::ST_IDLE);
    scan_issue    = (state == ffca_pkg::ST_SCAN) && (cur < CW'(ffca_pkg::SLOTS));
    ram_we        = (state == ffca_pkg::ST_MARK) || ((state == ffca_pkg::ST_FREE) && free_go);
    ram_wdata     = (state == ffca_pkg::ST_FREE);
    ram_waddr     = cur[SW-1:0];
    ram_raddr     = cur[SW-1:0];
  end

  ffca_ram #(
    .WIDTH (1),
    .DEPTH (ffca_pkg::SLOTS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ffca_pkg::ST_IDLE;
      overhead      <= ffca_pkg::OVH_RESET;
      slot_vld      <= '0;
      pend          <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        overhead <= cfg_wr_data;
      end
      if (ram_we) begin
        slot_vld[ram_waddr] <= 1'b1;
      end
      pend <= scan_issue;
      if (state == ffca_pkg::ST_EMIT && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    vld_q    <= slot_vld[ram_raddr];
    pend_idx <= cur[SW-1:0];
    unique case (state)
      ffca_pkg::ST_IDLE: begin
        need      <= need_in;
        run       <= '0;
        free_hi   <= s_axis_tdata[18:13];
        res_ok    <= (s_axis_tuser == ffca_pkg::MODE_FREE);
        res_start <= '0;
        res_end   <= '0;
        if (s_axis_tuser == ffca_pkg::MODE_FREE) begin
          cur <= CW'(s_axis_tdata[12:7]);
        end else begin
          cur <= '0;
        end
      end
      ffca_pkg::ST_SCAN: begin
        if (scan_hit) begin
          // rewind to the run start for marking
          cur        <= CW'(hit_first);
          first_slot <= hit_first;
          last_slot  <= hit_last;
          res_ok     <= 1'b1;
          res_start  <= ffca_pkg::slot_out(hit_first);
          res_end    <= ffca_pkg::slot_out(hit_last);
        end else begin
          if (scan_issue) begin
            cur <= cur + CW'(1);
          end
          if (pend) begin
            if (scan_free) begin
              if (run == '0) begin
                first_slot <= pend_idx;
              end
              run <= run + CW'(1);
            end else begin
              run <= '0;
            end
          end
        end
      end
      ffca_pkg::ST_MARK: begin
        cur <= cur + CW'(1);
      end
      ffca_pkg::ST_FREE: begin
        if (free_go) begin
          cur <= cur + CW'(1);
        end
      end
      ffca_pkg::ST_EMIT: begin
        if (out_free) begin
          m_axis_tdata <= {(ffca_pkg::OUT_TDATA_W - 2 * ffca_pkg::OUT_SLOT_W)'(0),
                           res_end, res_start};
          m_axis_tuser <= res_ok;
        end
      end
      default: begin
        cur <= cur;
      end
    endcase
  end

`include "first_fit_contiguous_allocator_assert.svh"

  `FFCA_ASSERT_NOW(a_scan_no_write, clk, rst, state == ffca_pkg::ST_SCAN, !ram_we)
  `FFCA_ASSERT_NOW(a_scan_run_short, clk, rst, state == ffca_pkg::ST_SCAN, run < need)
  `FFCA_ASSERT_NOW(a_mark_in_run, clk, rst, state == ffca_pkg::ST_MARK,
                   (cur[SW-1:0] >= first_slot) && (cur[SW-1:0] <= last_slot))
  `FFCA_ASSERT_NEXT(a_busy_not_ready, clk, rst, in_xfer, !s_axis_tready)

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import ffca_pkg::*;

  localparam int CLK_HALF = 4;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int N_RANDOM_PHASES = 8;
  localparam int CYCLE_LIMIT = 1500000;

  typedef struct packed {
    logic                  ok;
    logic [OUT_SLOT_W-1:0] start_slot;
    logic [OUT_SLOT_W-1:0] end_slot;
  } alloc_result_t;

  class alloc_scoreboard;
    bit [SLOTS-1:0]   free_map;
    logic [OVH_W-1:0] overhead;
    alloc_result_t    pending_results[$];
    int               errors;
    int               n_placed;
    int               n_refused;
    int               n_freed;

    function new();
      free_map = '1;
      overhead = OVH_RESET;
      errors = 0;
      n_placed = 0;
      n_refused = 0;
      n_freed = 0;
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    // Work out the free-map update and the answer for one accepted request.
    function void note_request(mode_t mode, logic [COUNT_W-1:0] count,
                               logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
      alloc_result_t r;
      int need;
      int run;
      int first;
      bit found;
      r = '0;
      if (mode == MODE_ALLOC) begin
        need = int'(count) + int'(overhead);
        run = 0;
        first = 0;
        found = 1'b0;
        if (need != 0 && need <= SLOTS) begin
          for (int i = 0; i < SLOTS && !found; i++) begin
            if (free_map[i]) begin
              if (run == 0) first = i;
              run++;
              if (run == need) found = 1'b1;
            end else begin
              run = 0;
            end
          end
        end
        if (found) begin
          for (int i = first; i < first + need; i++) free_map[i] = 1'b0;
          r.ok = 1'b1;
          r.start_slot = OUT_SLOT_W'(first);
          r.end_slot = OUT_SLOT_W'(first + need - 1);
          n_placed++;
        end else begin
          n_refused++;
        end
      end else begin
        for (int i = int'(lo); i <= int'(hi) && i < SLOTS; i++) free_map[i] = 1'b1;
        r.ok = 1'b1;
        n_freed++;
      end
      pending_results.push_back(r);
    endfunction

    function void check_result(logic ok, logic [OUT_TDATA_W-1:0] data);
      alloc_result_t want;
      logic [OUT_SLOT_W-1:0] got_start;
      logic [OUT_SLOT_W-1:0] got_end;
      got_start = data[OUT_SLOT_W-1:0];
      got_end = data[2*OUT_SLOT_W-1:OUT_SLOT_W];
      if (pending_results.size() == 0) begin
        $error("result transfer with no request outstanding: ok %0d start %0d end %0d",
               ok, got_start, got_end);
        errors++;
        return;
      end
      want = pending_results.pop_front();
      if (ok !== want.ok) begin
        $error("ok: expected %0d, got %0d", want.ok, ok);
        errors++;
      end
      if (got_start !== want.start_slot) begin
        $error("start_slot: expected %0d, got %0d", want.start_slot, got_start);
        errors++;
      end
      if (got_end !== want.end_slot) begin
        $error("end_slot: expected %0d, got %0d", want.end_slot, got_end);
        errors++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [OVH_W-1:0]       cfg_wr_data = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  alloc_scoreboard sb;
  bit              calm = 1'b0;
  int              cycle_count = 0;
  int              n_settings = 0;

  first_fit_contiguous_allocator u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #CLK_HALF clk = ~clk;

  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(99) >= 6);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Called and returns at a falling edge; leaves tvalid low.
  task automatic send_request(mode_t mode, logic [COUNT_W-1:0] count,
                              logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
    while (!calm && $urandom_range(99) < 6) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = mode;
    s_axis_tdata = IN_TDATA_W'({hi, lo, count});
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_request(mode, count, lo, hi);
    @(negedge clk);
    s_axis_tvalid = 1'b0;
  endtask

  task automatic alloc(logic [COUNT_W-1:0] count);
    send_request(MODE_ALLOC, count, '0, '0);
  endtask

  task automatic release_range(logic [RANGE_W-1:0] lo, logic [RANGE_W-1:0] hi);
    send_request(MODE_FREE, '0, lo, hi);
  endtask

  // Hold off until every answer is back and the block is ready again.
  task automatic wait_idle();
    while (sb.pending() != 0 || !s_axis_tready) @(negedge clk);
  endtask

  task automatic set_overhead(logic [OVH_W-1:0] value);
    wait_idle();
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.overhead = value;
    n_settings++;
  endtask

  task automatic random_requests(int n);
    int r;
    logic [COUNT_W-1:0] count;
    logic [RANGE_W-1:0] lo;
    logic [RANGE_W-1:0] hi;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if ($urandom_range(99) == 0) wait_idle();
      // Mostly small requests so the map fragments instead of just filling up.
      count = ($urandom_range(9) == 0) ? COUNT_W'($urandom_range(64))
                                       : COUNT_W'($urandom_range(12));
      lo = RANGE_W'($urandom_range(63));
      hi = RANGE_W'($urandom_range(63));
      if (r < 55) begin
        send_request(MODE_ALLOC, count, lo, hi);
      end else if (r < 95) begin
        if ($urandom_range(3) != 0) hi = (int'(lo) + 15 > 63) ? RANGE_W'(63)
                                         : lo + RANGE_W'($urandom_range(15));
        send_request(MODE_FREE, count, lo, hi);
      end else begin
        send_request(MODE_FREE, count, '0, RANGE_W'(SLOTS - 1));
      end
    end
  endtask

  initial begin
    logic [OVH_W-1:0] ovh;
    sb = new();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset overhead of 8.
    alloc(0);
    alloc(64);
    alloc(56);
    release_range(10, 5);
    alloc(48);
    alloc(0);
    release_range(0, 63);
    alloc(56);
    release_range(63, 63);
    release_range(0, 0);
    alloc(0);

    set_overhead(0);
    alloc(0);
    release_range(0, 63);
    alloc(64);
    release_range(31, 32);
    alloc(2);
    alloc(1);

    set_overhead(16);
    release_range(0, 63);
    alloc(48);
    release_range(42, 21);
    release_range(0, 63);
    alloc(49);
    alloc(0);

    for (int p = 0; p < N_RANDOM_PHASES; p++) begin
      case (p)
        0: ovh = 0;
        1: ovh = 16;
        2: ovh = 1;
        3: ovh = 15;
        4: ovh = OVH_RESET;
        default: ovh = OVH_W'($urandom_range(16));
      endcase
      set_overhead(ovh);
      calm = (p == 2);
      random_requests(ITEMS_PER_PHASE);
    end
    calm = 1'b0;

    wait_idle();
    repeat (32) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("%0d answers never arrived", sb.pending());
      sb.errors++;
    end

    $display("Covered %0d allocations placed, %0d refused and %0d range frees",
             sb.n_placed, sb.n_refused, sb.n_freed);
    $display("across %0d overhead settings, with random stalls on both streams",
             n_settings + 1);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/ffca_pkg.sv
rtl/core/ffca_ram.sv
rtl/core/first_fit_contiguous_allocator.sv
dv/tb_top.sv
